>>> design/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam int FRACTION_BITS_DEFAULT = 8;
  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MIN = 3'd4,
    CMD_MAX = 3'd5,
    CMD_INC = 3'd6,
    CMD_DEC = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  // side information carried along the pipe next to the divider state
  typedef struct packed {
    cmd_t              cmd;
    logic              lt;
    logic              eq;
    logic              gt;
    logic [WORD_W-1:0] res;
    status_t           status;
    logic              div_zero;
    logic              div_neg;
  } side_t;

endpackage
`default_nettype wire

>>> design/fixed_point_alu_q24_8_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Signed fixed-point ALU, Q24.8 by default (FRACTION_BITS fraction bits).
// Input stream: tuser carries the command (add, sub, mul, div, min, max,
// inc, dec), tdata the two raw 32-bit operands. Output stream: tdata carries
// the result and the a<b, a==b, a>b flags, tuser the status (ok, saturated,
// divide by zero). One result transfer per input transfer, in order.
// Mul and div round half away from zero; out-of-range results clamp.
// Pipeline: two front stages (compare/add, 32x32 product, then rounding),
// one restoring divider stage per quotient bit (32 + FRACTION_BITS), and
// the output register. All commands take the same path.
// Throughput: one transfer per cycle. The pipe advances as a whole whenever
// the output register is empty or being drained, so a stalled receiver
// freezes every stage; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits and holds tready low;
// payload is not reset.
module fixed_point_alu_q24_8_unit #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [31:0] result, [32] a_less,
                                          // [33] a_equal, [34] a_greater, zeros
  output logic [1:0]       m_axis_tuser   // [1:0] status
);

  localparam int W  = fpa_pkg::WORD_W;
  localparam int QW = W + FRACTION_BITS;  // quotient bits

  logic en;

  // divider chain, index 0 is the front output
  logic           valid_c [0:QW];
  fpa_pkg::side_t side_c  [0:QW];
  logic [QW-1:0]  num_c   [0:QW];
  logic [W-1:0]   den_c   [0:QW];
  logic [W-1:0]   rem_c   [0:QW];

  logic             out_valid;
  logic [W-1:0]     out_res;
  logic [2:0]       out_flags;
  fpa_pkg::status_t out_status;

  // whole pipe moves when the output slot is free or being taken
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  fpa_front #(
    .FRACTION_BITS(FRACTION_BITS),
    .QW           (QW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .cmd      (fpa_pkg::cmd_t'(s_axis_tuser)),
    .a        (s_axis_tdata[W-1:0]),
    .b        (s_axis_tdata[2*W-1:W]),
    .out_valid(valid_c[0]),
    .out_side (side_c[0]),
    .out_num  (num_c[0]),
    .out_den  (den_c[0])
  );

  assign rem_c[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    fpa_div_step #(
      .QW(QW)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (valid_c[i]),
      .in_side  (side_c[i]),
      .in_num   (num_c[i]),
      .in_den   (den_c[i]),
      .in_rem   (rem_c[i]),
      .out_valid(valid_c[i+1]),
      .out_side (side_c[i+1]),
      .out_num  (num_c[i+1]),
      .out_den  (den_c[i+1]),
      .out_rem  (rem_c[i+1])
    );
  end

  fpa_back #(
    .QW(QW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (valid_c[QW]),
    .in_side   (side_c[QW]),
    .in_num    (num_c[QW]),
    .in_den    (den_c[QW]),
    .in_rem    (rem_c[QW]),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_flags (out_flags),
    .out_status(out_status)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_flags, out_res};
  assign m_axis_tuser  = out_status;

endmodule
`default_nettype wire

>>> design/fpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_front #(
  parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEFAULT,
  parameter int QW            = fpa_pkg::WORD_W + FRACTION_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire fpa_pkg::cmd_t             cmd,
  input  wire logic [fpa_pkg::WORD_W-1:0] a,
  input  wire logic [fpa_pkg::WORD_W-1:0] b,
  output logic                           out_valid,
  output fpa_pkg::side_t                 out_side,
  output logic [QW-1:0]                  out_num,
  output logic [fpa_pkg::WORD_W-1:0]     out_den
);

  localparam int W = fpa_pkg::WORD_W;

  // stage A: compares, simple ops, product, divider setup
  logic                 valid_a;
  fpa_pkg::side_t       side_a;
  logic signed [2*W-1:0] prod_a;
  logic [QW-1:0]        num_a;
  logic [W-1:0]         den_a;

  fpa_pkg::side_t side_a_next;
  logic [W:0]     sum;
  logic [W:0]     dif;
  logic           lt;
  logic [W-1:0]   mag_a;
  logic [W-1:0]   mag_b;

  always_comb begin
    lt    = $signed(a) < $signed(b);
    sum   = {a[W-1], a} + {b[W-1], b};
    dif   = {a[W-1], a} - {b[W-1], b};
    mag_a = a[W-1] ? (~a + 1'b1) : a;
    mag_b = b[W-1] ? (~b + 1'b1) : b;
    side_a_next          = '0;
    side_a_next.cmd      = cmd;
    side_a_next.lt       = lt;
    side_a_next.eq       = (a == b);
    side_a_next.gt       = !lt && (a != b);
    side_a_next.status   = fpa_pkg::ST_OK;
    side_a_next.div_zero = (b == '0);
    side_a_next.div_neg  = a[W-1] ^ b[W-1];
    unique case (cmd)
      fpa_pkg::CMD_ADD: begin
        if (sum[W] != sum[W-1]) begin
          side_a_next.res    = sum[W] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
          side_a_next.status = fpa_pkg::ST_SAT;
        end else begin
          side_a_next.res = sum[W-1:0];
        end
      end
      fpa_pkg::CMD_SUB: begin
        if (dif[W] != dif[W-1]) begin
          side_a_next.res    = dif[W] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
          side_a_next.status = fpa_pkg::ST_SAT;
        end else begin
          side_a_next.res = dif[W-1:0];
        end
      end
      fpa_pkg::CMD_MIN: side_a_next.res = lt ? a : b;
      fpa_pkg::CMD_MAX: side_a_next.res = (!lt && (a != b)) ? a : b;
      fpa_pkg::CMD_INC: begin
        if (a == fpa_pkg::WORD_MAX) begin
          side_a_next.res    = fpa_pkg::WORD_MAX;
          side_a_next.status = fpa_pkg::ST_SAT;
        end else begin
          side_a_next.res = a + 1'b1;
        end
      end
      fpa_pkg::CMD_DEC: begin
        if (a == fpa_pkg::WORD_MIN) begin
          side_a_next.res    = fpa_pkg::WORD_MIN;
          side_a_next.status = fpa_pkg::ST_SAT;
        end else begin
          side_a_next.res = a - 1'b1;
        end
      end
      default: side_a_next.res = '0; // mul and div finish later
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_a <= side_a_next;
      prod_a <= $signed(a) * $signed(b);
      num_a  <= {mag_a, {FRACTION_BITS{1'b0}}};
      den_a  <= mag_b;
    end
  end

  // stage B: multiply rounding and clamp
  logic [2*W-1:0] pmag;
  logic [2*W-1:0] pround;
  fpa_pkg::side_t side_b_next;

  always_comb begin
    pmag   = prod_a[2*W-1] ? (~prod_a + 1'b1) : prod_a;
    pround = (pmag + ((2*W)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    side_b_next = side_a;
    if (side_a.cmd == fpa_pkg::CMD_MUL) begin
      if (prod_a[2*W-1]) begin
        if (pround > (2*W)'(fpa_pkg::WORD_MIN)) begin
          side_b_next.res    = fpa_pkg::WORD_MIN;
          side_b_next.status = fpa_pkg::ST_SAT;
        end else begin
          side_b_next.res = ~pround[W-1:0] + 1'b1;
        end
      end else begin
        if (pround > (2*W)'(fpa_pkg::WORD_MAX)) begin
          side_b_next.res    = fpa_pkg::WORD_MAX;
          side_b_next.status = fpa_pkg::ST_SAT;
        end else begin
          side_b_next.res = pround[W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side_b_next;
      out_num  <= num_a;
      out_den  <= den_a;
    end
  end

endmodule
`default_nettype wire

>>> design/fpa_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_step #(
  parameter int QW = fpa_pkg::WORD_W + fpa_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire fpa_pkg::side_t             in_side,
  input  wire logic [QW-1:0]              in_num,
  input  wire logic [fpa_pkg::WORD_W-1:0] in_den,
  input  wire logic [fpa_pkg::WORD_W-1:0] in_rem,
  output logic                            out_valid,
  output fpa_pkg::side_t                  out_side,
  output logic [QW-1:0]                   out_num,
  output logic [fpa_pkg::WORD_W-1:0]      out_den,
  output logic [fpa_pkg::WORD_W-1:0]      out_rem
);

  localparam int W = fpa_pkg::WORD_W;

  // one restoring step; quotient bits shift in where dividend bits leave
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;

  always_comb begin
    trial = {in_rem, in_num[QW-1]};
    diff  = trial - {1'b0, in_den};
    ge    = trial >= {1'b0, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      out_den  <= in_den;
      out_num  <= {in_num[QW-2:0], ge};
      out_rem  <= ge ? diff[W-1:0] : trial[W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> design/fpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module fpa_back #(
  parameter int QW = fpa_pkg::WORD_W + fpa_pkg::FRACTION_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire fpa_pkg::side_t             in_side,
  input  wire logic [QW-1:0]              in_num,
  input  wire logic [fpa_pkg::WORD_W-1:0] in_den,
  input  wire logic [fpa_pkg::WORD_W-1:0] in_rem,
  output logic                            out_valid,
  output logic [fpa_pkg::WORD_W-1:0]      out_res,
  output logic [2:0]                      out_flags,
  output fpa_pkg::status_t                out_status
);

  localparam int W = fpa_pkg::WORD_W;

  logic [QW:0]       q;
  logic              round_up;
  logic [W-1:0]      res_next;
  fpa_pkg::status_t  status_next;

  always_comb begin
    round_up    = {in_rem, 1'b0} >= {1'b0, in_den};
    q           = {1'b0, in_num} + (QW+1)'(round_up);
    res_next    = in_side.res;
    status_next = in_side.status;
    if (in_side.cmd == fpa_pkg::CMD_DIV) begin
      status_next = fpa_pkg::ST_OK;
      if (in_side.div_zero) begin
        res_next    = '0;
        status_next = fpa_pkg::ST_DIV0;
      end else if (in_side.div_neg) begin
        if (q > (QW+1)'(fpa_pkg::WORD_MIN)) begin
          res_next    = fpa_pkg::WORD_MIN;
          status_next = fpa_pkg::ST_SAT;
        end else begin
          res_next = ~q[W-1:0] + 1'b1;
        end
      end else begin
        if (q > (QW+1)'(fpa_pkg::WORD_MAX)) begin
          res_next    = fpa_pkg::WORD_MAX;
          status_next = fpa_pkg::ST_SAT;
        end else begin
          res_next = q[W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res    <= res_next;
      out_flags  <= {in_side.gt, in_side.eq, in_side.lt};
      out_status <= status_next;
    end
  end

endmodule
`default_nettype wire

>>> dv/alu_checker.sv
`timescale 1ns / 1ps
module alu_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  import fpa_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    status_t     status;
  } alu_result_t;

  alu_result_t expected_q[$];

  function automatic logic [31:0] saturate(input logic signed [65:0] x, inout status_t st);
    if (x > 66'sd2147483647) begin
      st = ST_SAT;
      return WORD_MAX;
    end
    if (x < -66'sd2147483648) begin
      st = ST_SAT;
      return WORD_MIN;
    end
    return x[31:0];
  endfunction

  function automatic alu_result_t compute_alu(input cmd_t cmd, input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    alu_result_t r;
    status_t st;
    logic signed [65:0] wa, wb, p, m, q;
    logic [65:0] ma, mb;
    st = ST_OK;
    wa = a;
    wb = b;
    r.value = '0;
    case (cmd)
      CMD_ADD: r.value = saturate(wa + wb, st);
      CMD_SUB: r.value = saturate(wa - wb, st);
      CMD_MUL: begin
        p = wa * wb;
        m = (p < 0) ? -p : p;
        m = (m + 66'sd128) >>> 8;
        r.value = saturate((p < 0) ? -m : m, st);
      end
      CMD_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
        end else begin
          ma = ((wa < 0) ? -wa : wa) << 8;
          mb = (wb < 0) ? -wb : wb;
          q = (2 * ma + mb) / (2 * mb);
          r.value = saturate(((a < 0) != (b < 0)) ? -q : q, st);
        end
      end
      CMD_MIN: r.value = (a < b) ? a : b;
      CMD_MAX: r.value = (a > b) ? a : b;
      CMD_INC: r.value = saturate(wa + 1, st);
      default: r.value = saturate(wa - 1, st);
    endcase
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    r.status = st;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst && s_axis_tvalid && s_axis_tready)
      expected_q.push_back(compute_alu(cmd_t'(s_axis_tuser), s_axis_tdata[31:0],
                                       s_axis_tdata[63:32]));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata[31:0], 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== want.value)
          report_mismatch("result", m_axis_tdata[31:0], want.value);
        if (m_axis_tdata[32] !== want.lt) report_mismatch("a_less", m_axis_tdata[32], want.lt);
        if (m_axis_tdata[33] !== want.eq) report_mismatch("a_equal", m_axis_tdata[33], want.eq);
        if (m_axis_tdata[34] !== want.gt)
          report_mismatch("a_greater", m_axis_tdata[34], want.gt);
        if (m_axis_tuser !== want.status) report_mismatch("status", m_axis_tuser, want.status);
      end
    end
    pending = expected_q.size();
  end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import fpa_pkg::*;

  localparam int LATENCY = FRACTION_BITS_DEFAULT + 35;
  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = CMD_ADD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          errors, pending, results_seen;
  int          cycles = 0;
  int          sent = 0;
  bit          hold_done = 0;

  fixed_point_alu_q24_8_unit dut (.*);
  alu_checker checker_i (.*);

  initial forever #10 clk = ~clk;

  // cycle budget: worst case is every item waiting a long stall on both sides
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'($urandom_range(0, 32'h3FF)) - 32'h200;  // around +/- 2.0
      4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input cmd_t cmd, input logic [31:0] a, input logic [31:0] b);
    s_axis_tvalid <= 1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {b, a};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      s_axis_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: random backpressure, with one long hold-off early on so the pipe fills
  initial begin
    int n;
    @(negedge rst);
    @(posedge clk);
    while (1) begin
      if (!hold_done && sent > 60) begin
        m_axis_tready <= 0;
        repeat (200) @(posedge clk);
        hold_done = 1;
      end
      n = pick_gap();
      if (n > 0) begin
        m_axis_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    cmd_t cmd;
    int   wait_cycles;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every command, saturation, divide by zero, equal min/max
    for (int c = 0; c < 8; c++) send(cmd_t'(c), 32'h0000_0300, 32'hFFFF_FF80);
    send(CMD_ADD, WORD_MAX, 32'd1);
    send(CMD_SUB, WORD_MIN, 32'd1);
    send(CMD_INC, WORD_MAX, WORD_MAX);
    send(CMD_DEC, WORD_MIN, WORD_MIN);
    send(CMD_MUL, WORD_MIN, WORD_MIN);
    send(CMD_MUL, WORD_MAX, WORD_MIN);
    send(CMD_MUL, 32'd1, 32'd128);              // half rounds away from zero
    send(CMD_MUL, 32'hFFFF_FFFF, 32'd128);
    send(CMD_DIV, WORD_MAX, 32'd0);
    send(CMD_DIV, WORD_MIN, 32'hFFFF_FFFF);
    send(CMD_DIV, 32'd1, 32'd512);
    send(CMD_DIV, 32'hFFFF_FFFF, 32'd512);
    send(CMD_MIN, 32'd77, 32'd77);
    send(CMD_MAX, WORD_MIN, WORD_MIN);
    send(CMD_MAX, WORD_MIN, WORD_MAX);
    send(CMD_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      logic [31:0] a, b;
      cmd = cmd_t'($urandom_range(0, 7));
      a = pick_operand();
      b = ($urandom_range(0, 7) == 0) ? a : pick_operand();
      if (cmd == CMD_DIV && $urandom_range(0, 9) == 0) b = 0;
      send(cmd, a, b);
      if (i % 97 == 0) idle_input(0);
      else idle_input(pick_gap());
    end
    s_axis_tvalid <= 0;

    // let the checker record the last transfer before watching the queue
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < LATENCY + 20) begin
      @(posedge clk);
      wait_cycles++;
    end

    $display("covered %0d operations over all eight commands, %0d results checked,",
             sent, results_seen);
    $display("with saturation, divide by zero and a long output stall included");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_div_step.sv
design/fpa_back.sv
design/fixed_point_alu_q24_8_unit.sv
dv/alu_checker.sv
dv/testbench.sv
